// File: rtl/core/rainbow_hue_wheel_color_macros.svh
// Assertion macros used by the checker of the hue wheel block.
`ifndef RAINBOW_HUE_WHEEL_COLOR_MACROS_SVH
`define RAINBOW_HUE_WHEEL_COLOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RHW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RHW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rhw_pkg.sv
// Shared types and constants of the hue wheel color block.
`default_nettype none

package rhw_pkg;

	localparam int POS_W  = 16;
	localparam int CHAN_W = 8;
	localparam int SPAN_W = 14;
	localparam int NUM_W  = SPAN_W + CHAN_W;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-1:0] RING_LENGTH_ADDR = 3'd0;
	localparam logic [POS_W-1:0]  RING_LENGTH_RST  = 16'd64;
	localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'd255;

	typedef struct packed {
		logic [POS_W-1:0] led_index;
		logic [POS_W-1:0] tick;
	} idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		SEG_GREEN_UP   = 3'd0,
		SEG_RED_DOWN   = 3'd1,
		SEG_BLUE_UP    = 3'd2,
		SEG_GREEN_DOWN = 3'd3,
		SEG_RED_UP     = 3'd4,
		SEG_BLUE_DOWN  = 3'd5
	} seg_t;

	typedef struct packed {
		logic [POS_W-1:0] b1;
		logic [POS_W-1:0] b2;
		logic [POS_W-1:0] b3;
		logic [POS_W-1:0] b4;
		logic [POS_W-1:0] b5;
		logic [POS_W-1:0] len;
	} bounds_t;

endpackage

`default_nettype wire

// File: rtl/core/rhw_bounds.sv
// Segment boundary generator: k*len/6 for k = 1..5, recomputed from the ring length.
`default_nettype none

module rhw_bounds (
	input  logic             clk,
	input  logic [rhw_pkg::POS_W-1:0] len,
	output rhw_pkg::bounds_t bnd
);
	import rhw_pkg::*;

	localparam int          RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP_SIX = 17'd87382;
	localparam int          RECIP_SHIFT = 19;
	localparam int          PROD_W      = POS_W + RECIP_W;

	logic [POS_W-1:0]  len_q;
	logic [SPAN_W-1:0] quot_q;
	bounds_t           bnd_q;

	logic [PROD_W-1:0] prod_c;
	logic [SPAN_W-1:0] quot_c;
	logic [POS_W-1:0]  qx_c;
	logic [POS_W-1:0]  six_c;
	logic [POS_W-1:0]  diff_c;
	logic [2:0]        rmd_c;
	bounds_t           bnd_c;

	// Floor of x/6 for x below 32: multiply by 43 and keep the bits above 2^8.
	function automatic logic [2:0] frac6(input logic [4:0] x);
		logic [10:0] p;
		p = 11'(x) * 11'd43;
		return p[10:8];
	endfunction

	// First stage: len/6 by reciprocal multiplication, exact for 16-bit lengths.
	assign prod_c = PROD_W'(len) * PROD_W'(RECIP_SIX);
	assign quot_c = prod_c[RECIP_SHIFT+SPAN_W-1:RECIP_SHIFT];

	// Second stage: k*len/6 = k*q + floor(k*r/6) with r = len - 6q.
	always_comb begin
		qx_c   = {2'b00, quot_q};
		six_c  = {quot_q, 2'b00} + {1'b0, quot_q, 1'b0};
		diff_c = len_q - six_c;
		rmd_c  = diff_c[2:0];
		bnd_c.b1  = qx_c + POS_W'(frac6(5'(rmd_c)));
		bnd_c.b2  = (qx_c << 1) + POS_W'(frac6(5'(rmd_c) * 5'd2));
		bnd_c.b3  = (qx_c << 1) + qx_c + POS_W'(frac6(5'(rmd_c) * 5'd3));
		bnd_c.b4  = (qx_c << 2) + POS_W'(frac6(5'(rmd_c) * 5'd4));
		bnd_c.b5  = (qx_c << 2) + qx_c + POS_W'(frac6(5'(rmd_c) * 5'd5));
		bnd_c.len = len_q;
	end

	always_ff @(posedge clk) begin
		len_q  <= len;
		quot_q <= quot_c;
		bnd_q  <= bnd_c;
	end

	assign bnd = bnd_q;

endmodule

`default_nettype wire

// File: rtl/core/rhw_mod.sv
// Pipelined restoring remainder unit: position = sum mod length, four bits a stage.
`default_nettype none

module rhw_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	output logic                      in_rdy,
	input  logic [rhw_pkg::POS_W-1:0] dvd,
	input  logic [rhw_pkg::POS_W-1:0] len,
	output logic                      out_vld,
	input  logic                      out_rdy,
	output logic [rhw_pkg::POS_W-1:0] rem
);
	import rhw_pkg::*;

	localparam int STEPS  = 4;
	localparam int STAGES = POS_W / STEPS;

	logic             vld_s [STAGES];
	logic [POS_W-1:0] dvd_s [STAGES];
	logic [POS_W-1:0] rem_s [STAGES];
	logic [STAGES:0]  rdy;

	assign rdy[STAGES] = out_rdy;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic             vld_prev;
		logic [POS_W-1:0] dvd_prev;
		logic [POS_W-1:0] rem_prev;
		logic [POS_W:0]   acc_c;
		logic [POS_W-1:0] rem_next;

		if (i == 0) begin : g_first
			assign vld_prev = in_vld;
			assign dvd_prev = dvd;
			assign rem_prev = '0;
		end else begin : g_next
			assign vld_prev = vld_s[i-1];
			assign dvd_prev = dvd_s[i-1];
			assign rem_prev = rem_s[i-1];
		end

		assign rdy[i] = !vld_s[i] || rdy[i+1];

		// Bring in the next dividend bit and subtract the length when it fits.
		always_comb begin
			acc_c = {1'b0, rem_prev};
			for (int j = 0; j < STEPS; j++) begin
				acc_c = {acc_c[POS_W-1:0], dvd_prev[POS_W-1-(i*STEPS+j)]};
				if (acc_c >= {1'b0, len}) begin
					acc_c = acc_c - {1'b0, len};
				end
			end
			rem_next = acc_c[POS_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && vld_prev) begin
				dvd_s[i] <= dvd_prev;
				rem_s[i] <= rem_next;
			end
		end
	end

	assign in_rdy  = rdy[0];
	assign out_vld = vld_s[STAGES-1];
	assign rem     = rem_s[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/rhw_div.sv
// Pipelined ramp divider: 8-bit quotient of offset*255 by segment span, four bits a stage.
`default_nettype none

module rhw_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	output logic                       in_rdy,
	input  logic [rhw_pkg::NUM_W-1:0]  num,
	input  logic [rhw_pkg::SPAN_W-1:0] den,
	input  rhw_pkg::seg_t              seg_in,
	output logic                       out_vld,
	input  logic                       out_rdy,
	output logic [rhw_pkg::CHAN_W-1:0] quo,
	output rhw_pkg::seg_t              seg_out
);
	import rhw_pkg::*;

	localparam int STEPS  = 4;
	localparam int STAGES = CHAN_W / STEPS;

	logic              vld_s [STAGES];
	logic [NUM_W-1:0]  rem_s [STAGES];
	logic [SPAN_W-1:0] den_s [STAGES];
	logic [CHAN_W-1:0] quo_s [STAGES];
	seg_t              seg_s [STAGES];
	logic [STAGES:0]   rdy;

	assign rdy[STAGES] = out_rdy;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic              vld_prev;
		logic [NUM_W-1:0]  rem_prev;
		logic [SPAN_W-1:0] den_prev;
		logic [CHAN_W-1:0] quo_prev;
		seg_t              seg_prev;
		logic [NUM_W-1:0]  acc_c;
		logic [NUM_W-1:0]  trial_c;
		logic [CHAN_W-1:0] quo_c;

		if (i == 0) begin : g_first
			assign vld_prev = in_vld;
			assign rem_prev = num;
			assign den_prev = den;
			assign quo_prev = '0;
			assign seg_prev = seg_in;
		end else begin : g_next
			assign vld_prev = vld_s[i-1];
			assign rem_prev = rem_s[i-1];
			assign den_prev = den_s[i-1];
			assign quo_prev = quo_s[i-1];
			assign seg_prev = seg_s[i-1];
		end

		assign rdy[i] = !vld_s[i] || rdy[i+1];

		// One quotient bit per step, most significant first.
		always_comb begin
			acc_c   = rem_prev;
			quo_c   = quo_prev;
			trial_c = '0;
			for (int j = 0; j < STEPS; j++) begin
				trial_c = NUM_W'(den_prev) << (CHAN_W-1-(i*STEPS+j));
				if (acc_c >= trial_c) begin
					acc_c = acc_c - trial_c;
					quo_c[CHAN_W-1-(i*STEPS+j)] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && vld_prev) begin
				rem_s[i] <= acc_c;
				den_s[i] <= den_prev;
				quo_s[i] <= quo_c;
				seg_s[i] <= seg_prev;
			end
		end
	end

	assign in_rdy  = rdy[0];
	assign out_vld = vld_s[STAGES-1];
	assign quo     = quo_s[STAGES-1];
	assign seg_out = seg_s[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/rainbow_hue_wheel_color.sv
// Top level of the six-segment hue wheel color generator with its APB register.
// A request passes through ten registered stages on its way from idx to rgb.
// Throughput: one request per clock unless rgb_stall holds the ten-stage valid/stall pipeline.
// Reset: arst_n clears all valid bits and sets ring_length to 64; no clearing pass.
// Boundaries follow a length write through len_q/quot_q, then bnd_q, ahead of any request needing them.
`default_nettype none

module rainbow_hue_wheel_color (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rhw_pkg::APB_AW-1:0] paddr,
	input  logic [rhw_pkg::APB_DW-1:0] pwdata,
	output logic [rhw_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       idx_valid,
	output logic                       idx_stall,
	input  rhw_pkg::idx_t              idx,
	output logic                       rgb_valid,
	input  logic                       rgb_stall,
	output rhw_pkg::rgb_t              rgb
);
	import rhw_pkg::*;

	// Configuration register. A length of zero behaves as a length of one.
	logic [POS_W-1:0] ring_length_q;
	logic [POS_W-1:0] len_eff;

	// Stage 1 holds the wrapped sum of index and tick.
	logic             vld_s1;
	logic [POS_W-1:0] sum_s1;
	logic             rdy_s1;

	// The remainder unit fills stages 2 to 5.
	logic             mod_rdy;
	logic             mod_vld;
	logic [POS_W-1:0] pos_m;

	// Stage 6 holds the wheel position and the segment it falls in.
	logic             vld_s6;
	seg_t             seg_s6;
	logic [POS_W-1:0] pos_s6;
	logic             rdy_s6;
	seg_t             seg_c;

	// Stage 7 holds the ramp numerator and the segment span.
	logic              vld_s7;
	seg_t              seg_s7;
	logic [NUM_W-1:0]  num_s7;
	logic [SPAN_W-1:0] span_s7;
	logic              rdy_s7;
	logic [POS_W-1:0]  lo_c;
	logic [POS_W-1:0]  hi_c;
	logic [POS_W-1:0]  off_c;
	logic [POS_W-1:0]  span_c;
	logic [NUM_W-1:0]  num_c;

	// The ramp divider fills stages 8 and 9.
	logic              div_rdy;
	logic              div_vld;
	logic [CHAN_W-1:0] ramp_d;
	seg_t              seg_d;

	// Stage 10 is the output register.
	logic vld_s10;
	rgb_t rgb_s10;
	logic rdy_s10;
	rgb_t rgb_c;

	bounds_t bnd;

	// Register port. Writes land in the access cycle; reads return the length at address 0 and zero elsewhere.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_length_q <= RING_LENGTH_RST;
		end else if (psel && penable && pwrite && pready && paddr == RING_LENGTH_ADDR) begin
			ring_length_q <= pwdata[POS_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == RING_LENGTH_ADDR) ?
		{{(APB_DW-POS_W){1'b0}}, ring_length_q} : '0;

	assign len_eff = (ring_length_q == '0) ? {{(POS_W-1){1'b0}}, 1'b1} : ring_length_q;

	// The boundaries depend only on the length, so they are kept in registers
	// beside the pipeline rather than carried with every request.
	rhw_bounds u_bounds (
		.clk (clk),
		.len (len_eff),
		.bnd (bnd)
	);

	// Stage 1: index plus tick, wrapping at 16 bits. Each stage loads when it
	// is empty or when the stage after it moves, so bubbles close up while
	// the output is stalled.
	assign rdy_s1    = !vld_s1 || mod_rdy;
	assign idx_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= idx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && idx_valid) begin
			sum_s1 <= POS_W'(idx.led_index + idx.tick);
		end
	end

	// Stages 2 to 5: position on the wheel, sum modulo the effective length.
	rhw_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_rdy  (mod_rdy),
		.dvd     (sum_s1),
		.len     (len_eff),
		.out_vld (mod_vld),
		.out_rdy (rdy_s6),
		.rem     (pos_m)
	);

	// Stage 6: the first segment whose upper boundary lies above the position.
	// Empty segments of short rings are skipped by this priority order.
	always_comb begin
		if (pos_m < bnd.b1) begin
			seg_c = SEG_GREEN_UP;
		end else if (pos_m < bnd.b2) begin
			seg_c = SEG_RED_DOWN;
		end else if (pos_m < bnd.b3) begin
			seg_c = SEG_BLUE_UP;
		end else if (pos_m < bnd.b4) begin
			seg_c = SEG_GREEN_DOWN;
		end else if (pos_m < bnd.b5) begin
			seg_c = SEG_RED_UP;
		end else begin
			seg_c = SEG_BLUE_DOWN;
		end
	end

	assign rdy_s6 = !vld_s6 || rdy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= mod_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && mod_vld) begin
			seg_s6 <= seg_c;
			pos_s6 <= pos_m;
		end
	end

	// Stage 7: offset into the segment times 255, and the segment span. The
	// chosen segment always contains the position, so the span is never zero.
	always_comb begin
		case (seg_s6)
			SEG_GREEN_UP: begin
				lo_c = '0;
				hi_c = bnd.b1;
			end
			SEG_RED_DOWN: begin
				lo_c = bnd.b1;
				hi_c = bnd.b2;
			end
			SEG_BLUE_UP: begin
				lo_c = bnd.b2;
				hi_c = bnd.b3;
			end
			SEG_GREEN_DOWN: begin
				lo_c = bnd.b3;
				hi_c = bnd.b4;
			end
			SEG_RED_UP: begin
				lo_c = bnd.b4;
				hi_c = bnd.b5;
			end
			SEG_BLUE_DOWN: begin
				lo_c = bnd.b5;
				hi_c = bnd.len;
			end
			default: begin
				lo_c = '0;
				hi_c = bnd.len;
			end
		endcase
		off_c  = pos_s6 - lo_c;
		span_c = hi_c - lo_c;
		num_c  = {off_c[SPAN_W-1:0], {CHAN_W{1'b0}}} - NUM_W'(off_c[SPAN_W-1:0]);
	end

	assign rdy_s7 = !vld_s7 || div_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (rdy_s7) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			seg_s7  <= seg_s6;
			num_s7  <= num_c;
			span_s7 <= span_c[SPAN_W-1:0];
		end
	end

	// Stages 8 and 9: the truncated ramp value, 0 to 254.
	rhw_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s7),
		.in_rdy  (div_rdy),
		.num     (num_s7),
		.den     (span_s7),
		.seg_in  (seg_s7),
		.out_vld (div_vld),
		.out_rdy (rdy_s10),
		.quo     (ramp_d),
		.seg_out (seg_d)
	);

	// Stage 10: one channel ramps, one is full and one is off in every segment.
	always_comb begin
		case (seg_d)
			SEG_GREEN_UP: begin
				rgb_c.red   = CHAN_MAX;
				rgb_c.green = ramp_d;
				rgb_c.blue  = '0;
			end
			SEG_RED_DOWN: begin
				rgb_c.red   = CHAN_MAX - ramp_d;
				rgb_c.green = CHAN_MAX;
				rgb_c.blue  = '0;
			end
			SEG_BLUE_UP: begin
				rgb_c.red   = '0;
				rgb_c.green = CHAN_MAX;
				rgb_c.blue  = ramp_d;
			end
			SEG_GREEN_DOWN: begin
				rgb_c.red   = '0;
				rgb_c.green = CHAN_MAX - ramp_d;
				rgb_c.blue  = CHAN_MAX;
			end
			SEG_RED_UP: begin
				rgb_c.red   = ramp_d;
				rgb_c.green = '0;
				rgb_c.blue  = CHAN_MAX;
			end
			SEG_BLUE_DOWN: begin
				rgb_c.red   = CHAN_MAX;
				rgb_c.green = '0;
				rgb_c.blue  = CHAN_MAX - ramp_d;
			end
			default: begin
				rgb_c = '0;
			end
		endcase
	end

	assign rdy_s10 = !vld_s10 || !rgb_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (rdy_s10) begin
			vld_s10 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s10 && div_vld) begin
			rgb_s10 <= rgb_c;
		end
	end

	assign rgb_valid = vld_s10;
	assign rgb       = rgb_s10;

endmodule

`default_nettype wire

// File: rtl/core/rhw_checker.sv
// Port-level checker of the hue wheel block and its bind to the top level.
`default_nettype none
`include "rainbow_hue_wheel_color_macros.svh"

module rhw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          idx_valid,
	input logic          idx_stall,
	input logic          rgb_valid,
	input logic          rgb_stall,
	input rhw_pkg::rgb_t rgb
);
	import rhw_pkg::*;

	localparam int DEPTH = 10;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic             idx_acc;
	logic             rgb_acc;
	logic [CNT_W-1:0] inflight_q;

	assign idx_acc = idx_valid && !idx_stall;
	assign rgb_acc = rgb_valid && !rgb_stall;

	// Requests taken in and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(idx_acc) - CNT_W'(rgb_acc);
		end
	end

	`RHW_ASSERT_NEXT(a_rgb_hold, clk, arst_n, rgb_valid && rgb_stall, rgb_valid && $stable(rgb), "rgb changed while stalled")
	`RHW_ASSERT_NOW(a_no_stall_when_empty, clk, arst_n, !rgb_valid, !idx_stall, "idx stalled with an empty output")
	`RHW_ASSERT_NOW(a_hue_shape, clk, arst_n, rgb_valid, (rgb.red == CHAN_MAX || rgb.green == CHAN_MAX || rgb.blue == CHAN_MAX) && (rgb.red == '0 || rgb.green == '0 || rgb.blue == '0), "color lacks a full or an off channel")
	`RHW_ASSERT_NOW(a_no_invented, clk, arst_n, rgb_valid, inflight_q != '0, "result without a pending request")

endmodule

bind rainbow_hue_wheel_color rhw_checker u_rhw_checker (.*);

`default_nettype wire
